/* rtl/rocsc_pkg.sv */
// Package for the report-on-change sleep controller.
// Holds event and wake codes, register indexes, field widths and reset values.
// No dependencies.
package rocsc_pkg;

  localparam int LEVEL_BITS_DEF = 18;
  localparam int FUNC_W         = 3;
  localparam int COUNT_W        = 16;
  localparam int DIFF_W         = 16;
  localparam int SECS_W         = 13;
  localparam int WAKE_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  // Stored level after reset, truncated to the level width where needed.
  localparam int LEVEL_INVALID  = -100000;

  localparam logic [DIFF_W-1:0]  MIN_DIFF_RST  = 16'd50;
  localparam logic [COUNT_W-1:0] HEARTBEAT_RST = 16'd6;
  localparam logic [SECS_W-1:0]  PERIOD_RST    = 13'd600;
  localparam logic [SECS_W-1:0]  MODEM_RST     = 13'd1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MEASURE   = 3'd0,
    FUNC_POSTED    = 3'd1,
    FUNC_CANCELED  = 3'd2,
    FUNC_SLEEP     = 3'd3,
    FUNC_ENTER_CFG = 3'd4,
    FUNC_LEAVE_CFG = 3'd5
  } func_e;

  typedef enum logic [WAKE_W-1:0] {
    WAKE_RF_CAL = 2'd0,
    WAKE_NO_CAL = 2'd1,
    WAKE_OFF    = 2'd2
  } wake_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DIFF  = 2'd0,
    CFG_HEARTBEAT = 2'd1,
    CFG_PERIOD    = 2'd2,
    CFG_MODEM     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic post;
    logic measure;
    logic config_mode;
  } flags_t;

  typedef struct packed {
    logic              sleep_now;
    wake_e             wake_mode;
    logic [SECS_W-1:0] secs;
  } sleep_t;

  typedef struct packed {
    logic [DIFF_W-1:0]  min_diff;
    logic [COUNT_W-1:0] heartbeat;
    logic [SECS_W-1:0]  period;
    logic [SECS_W-1:0]  modem;
  } cfg_t;

endpackage

/* rtl/rocsc_event.sv */
// Next-state logic of the report-on-change sleep controller for one event.
// Depends on rocsc_pkg.
module rocsc_event #(
  parameter int LEVEL_BITS = rocsc_pkg::LEVEL_BITS_DEF
) (
  input  logic [rocsc_pkg::FUNC_W-1:0]  func_i,
  input  logic signed [LEVEL_BITS-1:0]  level_i,
  input  rocsc_pkg::cfg_t               cfg_i,
  input  rocsc_pkg::flags_t             flags_i,
  input  logic [rocsc_pkg::COUNT_W-1:0] count_i,
  input  logic signed [LEVEL_BITS-1:0]  stored_i,
  output rocsc_pkg::flags_t             flags_o,
  output logic [rocsc_pkg::COUNT_W-1:0] count_o,
  output logic signed [LEVEL_BITS-1:0]  stored_o,
  output rocsc_pkg::sleep_t             sleep_o
);
  import rocsc_pkg::*;

  localparam int CmpW = (LEVEL_BITS > DIFF_W) ? LEVEL_BITS : DIFF_W;

  logic signed [LEVEL_BITS:0] diff;
  logic [LEVEL_BITS-1:0]      diff_abs;
  logic [CmpW-1:0]            mag_ext;
  logic [CmpW-1:0]            min_ext;
  logic                       report;

  // The magnitude of an (L+1)-bit difference of two L-bit levels fits in L bits.
  assign diff     = {stored_i[LEVEL_BITS-1], stored_i} - {level_i[LEVEL_BITS-1], level_i};
  assign diff_abs = diff[LEVEL_BITS] ? LEVEL_BITS'(-diff) : LEVEL_BITS'(diff);
  assign mag_ext  = CmpW'(diff_abs);
  assign min_ext  = CmpW'(cfg_i.min_diff);
  assign report   = (count_i == '0) || (mag_ext >= min_ext);

  always_comb begin
    flags_o           = flags_i;
    count_o           = count_i;
    stored_o          = stored_i;
    sleep_o.sleep_now = 1'b0;
    sleep_o.wake_mode = WAKE_RF_CAL;
    sleep_o.secs      = '0;
    case (func_e'(func_i))
      FUNC_MEASURE: begin
        if (report) begin
          stored_o        = level_i;
          flags_o.post    = 1'b1;
          flags_o.measure = 1'b0;
        end
      end
      FUNC_POSTED: begin
        count_o         = cfg_i.heartbeat;
        flags_o.post    = 1'b0;
        flags_o.measure = 1'b1;
      end
      FUNC_CANCELED: begin
        count_o         = '0;
        flags_o.post    = 1'b0;
        flags_o.measure = 1'b1;
      end
      FUNC_SLEEP: begin
        sleep_o.sleep_now = 1'b1;
        if (flags_i.post) begin
          sleep_o.wake_mode = WAKE_NO_CAL;
          sleep_o.secs      = cfg_i.modem;
        end else if (flags_i.config_mode) begin
          sleep_o.wake_mode = WAKE_RF_CAL;
          sleep_o.secs      = cfg_i.modem;
        end else begin
          sleep_o.wake_mode = WAKE_OFF;
          sleep_o.secs      = cfg_i.period;
          // count the heartbeat down, saturate at zero
          if (count_i != '0) begin
            count_o = count_i - COUNT_W'(1);
          end
        end
      end
      FUNC_ENTER_CFG: begin
        flags_o.config_mode = 1'b1;
        flags_o.post        = 1'b0;
        flags_o.measure     = 1'b0;
        sleep_o.sleep_now   = 1'b1;
        sleep_o.wake_mode   = WAKE_RF_CAL;
        sleep_o.secs        = cfg_i.modem;
      end
      FUNC_LEAVE_CFG: begin
        flags_o.config_mode = 1'b0;
        flags_o.post        = 1'b0;
        flags_o.measure     = 1'b1;
        sleep_o.sleep_now   = 1'b1;
        sleep_o.wake_mode   = WAKE_OFF;
        sleep_o.secs        = cfg_i.modem;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/report_on_change_sleep_controller.sv */
// Top level of the report-on-change sleep controller: config registers,
// state registers and the result register. Depends on rocsc_pkg, rocsc_event.
//
// channel   direction  tvalid/tready  payload
// s_axis    in         accept on both tdata: level; tuser: func
// m_axis    out        accept on both tdata: flags, last level, countdown, sleep
// cfg       in         cfg_we_i       cfg_idx_i, cfg_data_i, no read-back
//
// An event's next state is formed in one pass through rocsc_event and
// lands in the state and result registers at the same edge.
// One event per cycle is sustained while the result side keeps tready high.
// A stalled result holds in the output register; a new event is taken in
// the cycle the waiting result leaves. Reset restores register defaults and
// the state at once, with no clearing pass.
module report_on_change_sleep_controller #(
  parameter int LEVEL_BITS = rocsc_pkg::LEVEL_BITS_DEF,
  localparam int InW       = ((LEVEL_BITS + 7) / 8) * 8,
  localparam int OutBits   = LEVEL_BITS + 3 + rocsc_pkg::COUNT_W + 1
                             + rocsc_pkg::WAKE_W + rocsc_pkg::SECS_W,
  localparam int OutW      = ((OutBits + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rocsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rocsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata fields from bit 0: level
  input  logic [InW-1:0]                   s_axis_tdata,
  // tuser fields from bit 0: func
  input  logic [rocsc_pkg::FUNC_W-1:0]     s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata fields from bit 0: post_pending, measure_pending, config_pending,
  // last_level, countdown, sleep_now, wake_mode, sleep_seconds, zero fill
  output logic [OutW-1:0]                  m_axis_tdata
);
  import rocsc_pkg::*;

  localparam logic signed [LEVEL_BITS-1:0] LevelRst = LEVEL_BITS'(LEVEL_INVALID);

  cfg_t                        cfg_q;
  flags_t                      flags_q, flags_d;
  logic [COUNT_W-1:0]          count_q, count_d;
  logic signed [LEVEL_BITS-1:0] stored_q, stored_d;
  sleep_t                      sleep_d;
  logic                        out_valid_q;
  logic [OutW-1:0]             out_data_q, out_data_d;
  logic                        in_acc;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_diff  <= MIN_DIFF_RST;
      cfg_q.heartbeat <= HEARTBEAT_RST;
      cfg_q.period    <= PERIOD_RST;
      cfg_q.modem     <= MODEM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_DIFF:  cfg_q.min_diff  <= cfg_data_i[DIFF_W-1:0];
        CFG_HEARTBEAT: cfg_q.heartbeat <= cfg_data_i[COUNT_W-1:0];
        CFG_PERIOD:    cfg_q.period    <= cfg_data_i[SECS_W-1:0];
        CFG_MODEM:     cfg_q.modem     <= cfg_data_i[SECS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rocsc_event #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_event (
    .func_i  (s_axis_tuser),
    .level_i (s_axis_tdata[LEVEL_BITS-1:0]),
    .cfg_i   (cfg_q),
    .flags_i (flags_q),
    .count_i (count_q),
    .stored_i(stored_q),
    .flags_o (flags_d),
    .count_o (count_d),
    .stored_o(stored_d),
    .sleep_o (sleep_d)
  );

  assign out_data_d = OutW'({sleep_d.secs, sleep_d.wake_mode, sleep_d.sleep_now, count_d,
                             stored_d, flags_d.config_mode, flags_d.measure,
                             flags_d.post});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q.post        <= 1'b0;
      flags_q.measure     <= 1'b1;
      flags_q.config_mode <= 1'b0;
      count_q             <= '0;
      stored_q            <= LevelRst;
      out_valid_q         <= 1'b0;
    end else begin
      if (in_acc) begin
        flags_q  <= flags_d;
        count_q  <= count_d;
        stored_q <= stored_d;
      end
      // hold a stalled result, drop it once taken
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

`ifndef SYNTHESIS
  a_post_measure_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(flags_q.post && flags_q.measure))
    else $error("post and measure flags both set");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  a_state_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(count_q) && $stable(stored_q) && $stable(flags_q))
    else $error("state changed without a request");

  a_cancel_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser == FUNC_CANCELED)
    |=> (count_q == '0) && !flags_q.post && flags_q.measure)
    else $error("cancel did not clear countdown and post");
`endif

endmodule

/* bench/sleep_report_checker.sv */
// Scoreboard for the report-on-change sleep controller: follows register writes
// and accepted requests, predicts each report and compares it with the output.
// Depends on rocsc_pkg.
module sleep_report_checker #(
  parameter int LEVEL_BITS = rocsc_pkg::LEVEL_BITS_DEF,
  parameter int IN_W       = 24,
  parameter int OUT_W      = 56
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rocsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rocsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             req_valid_i,
  input  logic                             req_ready_i,
  // fields from bit 0: level
  input  logic [IN_W-1:0]                  req_data_i,
  // fields from bit 0: func
  input  logic [rocsc_pkg::FUNC_W-1:0]     req_user_i,
  input  logic                             rsp_valid_i,
  input  logic                             rsp_ready_i,
  // fields from bit 0: post, measure, config, level, countdown, sleep, wake, seconds
  input  logic [OUT_W-1:0]                 rsp_data_i,
  output int                               mismatches_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rocsc_pkg::*;

  // Highest field first, so the struct lines up with the packed result bus.
  typedef struct packed {
    logic [SECS_W-1:0]     secs;
    logic [WAKE_W-1:0]     wake;
    logic                  sleep_now;
    logic [COUNT_W-1:0]    countdown;
    logic [LEVEL_BITS-1:0] level;
    logic                  config_mode;
    logic                  measure;
    logic                  post;
  } report_t;

  localparam int RptW = $bits(report_t);

  string field_names [8] = '{"post_pending", "measure_pending", "config_pending",
                             "last_level", "countdown", "sleep_now", "wake_mode",
                             "sleep_seconds"};

  logic [DIFF_W-1:0]            deadband;
  logic [COUNT_W-1:0]           reload;
  logic [SECS_W-1:0]            period_s;
  logic [SECS_W-1:0]            modem_s;
  logic signed [LEVEL_BITS-1:0] stored;
  logic [COUNT_W-1:0]           beats;
  logic                         post_f;
  logic                         meas_f;
  logic                         cfg_f;
  report_t                      expected_reports [$];
  int                           fail_count;

  function automatic void reset_model();
    deadband = MIN_DIFF_RST;
    reload   = HEARTBEAT_RST;
    period_s = PERIOD_RST;
    modem_s  = MODEM_RST;
    stored   = LEVEL_BITS'(LEVEL_INVALID);
    beats    = '0;
    post_f   = 1'b0;
    meas_f   = 1'b1;
    cfg_f    = 1'b0;
    expected_reports.delete();
  endfunction

  function automatic void choose_sleep(output logic [WAKE_W-1:0] wake,
                                       output logic [SECS_W-1:0] secs);
    if (post_f) begin
      wake = WAKE_NO_CAL;
      secs = modem_s;
    end else if (cfg_f) begin
      wake = WAKE_RF_CAL;
      secs = modem_s;
    end else begin
      wake = WAKE_OFF;
      secs = period_s;
      if (beats != '0) beats = beats - 1'b1;
    end
  endfunction

  function automatic report_t next_report(input logic [FUNC_W-1:0] func,
                                          input logic signed [LEVEL_BITS-1:0] lvl);
    report_t r;
    longint  gap;
    r = '0;
    case (func)
      FUNC_MEASURE: begin
        gap = longint'(stored) - longint'(lvl);
        if (gap < 0) gap = -gap;
        if (beats == '0 || gap >= longint'(deadband)) begin
          stored = lvl;
          post_f = 1'b1;
          meas_f = 1'b0;
        end
      end
      FUNC_POSTED: begin
        beats  = reload;
        post_f = 1'b0;
        meas_f = 1'b1;
      end
      FUNC_CANCELED: begin
        beats  = '0;
        post_f = 1'b0;
        meas_f = 1'b1;
      end
      FUNC_SLEEP: begin
        r.sleep_now = 1'b1;
        choose_sleep(r.wake, r.secs);
      end
      FUNC_ENTER_CFG: begin
        cfg_f  = 1'b1;
        post_f = 1'b0;
        meas_f = 1'b0;
        r.sleep_now = 1'b1;
        choose_sleep(r.wake, r.secs);
      end
      FUNC_LEAVE_CFG: begin
        cfg_f  = 1'b0;
        post_f = 1'b0;
        meas_f = 1'b1;
        r.sleep_now = 1'b1;
        r.wake      = WAKE_OFF;
        r.secs      = modem_s;
      end
      default: ;
    endcase
    r.post        = post_f;
    r.measure     = meas_f;
    r.config_mode = cfg_f;
    r.level       = stored;
    r.countdown   = beats;
    return r;
  endfunction

  function automatic void field_values(input report_t r, output longint v [8]);
    v[0] = longint'(r.post);
    v[1] = longint'(r.measure);
    v[2] = longint'(r.config_mode);
    v[3] = longint'(signed'(r.level));
    v[4] = longint'(r.countdown);
    v[5] = longint'(r.sleep_now);
    v[6] = longint'(r.wake);
    v[7] = longint'(r.secs);
  endfunction

  function automatic void check_report(input report_t got);
    report_t want;
    longint  w [8];
    longint  g [8];
    if (expected_reports.size() == 0) begin
      $display("%0t: report with nothing expected: %h", $time, got);
      fail_count++;
      return;
    end
    want = expected_reports.pop_front();
    field_values(want, w);
    field_values(got, g);
    for (int i = 0; i < 8; i++) begin
      if (w[i] != g[i]) begin
        $display("%0t: %s expected %0d, got %0d", $time, field_names[i], w[i], g[i]);
        fail_count++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      fail_count = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_DIFF:  deadband = cfg_data_i;
          CFG_HEARTBEAT: reload   = cfg_data_i;
          CFG_PERIOD:    period_s = cfg_data_i[SECS_W-1:0];
          CFG_MODEM:     modem_s  = cfg_data_i[SECS_W-1:0];
          default: ;
        endcase
      end
      // Compare before queuing: a report never leaves in the cycle its request enters.
      if (rsp_valid_i && rsp_ready_i) check_report(report_t'(rsp_data_i[RptW-1:0]));
      if (req_valid_i && req_ready_i) begin
        expected_reports.push_back(next_report(req_user_i, req_data_i[LEVEL_BITS-1:0]));
      end
      mismatches_o <= fail_count;
      pending_o    <= expected_reports.size();
    end
  end

endmodule

/* bench/tb_report_on_change_sleep_controller.sv */
// Testbench top for the report-on-change sleep controller: clock, reset,
// register writes, request and stall stimulus, and the final verdict.
// Depends on rocsc_pkg, report_on_change_sleep_controller, sleep_report_checker.
module tb_report_on_change_sleep_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import rocsc_pkg::*;

  localparam int LB         = LEVEL_BITS_DEF;
  localparam int InW        = ((LB + 7) / 8) * 8;
  localparam int OutBits    = LB + 3 + COUNT_W + 1 + WAKE_W + SECS_W;
  localparam int OutW       = ((OutBits + 7) / 8) * 8;
  localparam int CycleLimit = 400000;

  // Function codes the block does not decode.
  localparam logic [FUNC_W-1:0] FUNC_RSVD_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InW-1:0]        s_axis_tdata;
  logic [FUNC_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutW-1:0]       m_axis_tdata;

  int                    mismatches;
  int                    pending;
  int                    send_idle_pct;
  int                    stall_pct;
  int                    sent;
  int                    next_pause;
  int                    deadband_now;
  int                    cycle_cnt;
  logic signed [LB-1:0]  base_level;

  always #5ns clk_i = ~clk_i;

  report_on_change_sleep_controller #(.LEVEL_BITS(LB)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sleep_report_checker #(.LEVEL_BITS(LB), .IN_W(InW), .OUT_W(OutW)) u_report_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_user_i   (s_axis_tuser),
    .rsp_valid_i  (m_axis_tvalid),
    .rsp_ready_i  (m_axis_tready),
    .rsp_data_i   (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  function automatic logic [LB-1:0] rand_level();
    return LB'($urandom);
  endfunction

  // Level close to the last one, within about twice the deadband, 60002 at most.
  function automatic logic [LB-1:0] near_level();
    int span;
    int off;
    span = (deadband_now > 30000) ? 30000 : deadband_now;
    off  = int'($urandom_range(4 * span + 4)) - (2 * span + 2);
    return base_level + LB'(off);
  endfunction

  task automatic send(input logic [FUNC_W-1:0] func, input logic [LB-1:0] lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InW'(lvl);
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    if (func <= FUNC_LEAVE_CFG) sent++;
  endtask

  // Drop valid and hold until every report is back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] min_diff, beats,
                              input logic [CFG_DATA_W-1:0] period, modem);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MIN_DIFF;
    cfg_data_i <= min_diff;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HEARTBEAT;
    cfg_data_i <= beats;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PERIOD;
    cfg_data_i <= period;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MODEM;
    cfg_data_i <= modem;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    deadband_now = int'(min_diff);
  endtask

  // Wake, measure, mostly settle the post, then sleep a while.
  task automatic measure_cycle();
    int pick;
    base_level = ($urandom_range(99) < 15) ? rand_level() : near_level();
    send(FUNC_MEASURE, base_level);
    repeat ($urandom_range(2)) send(FUNC_SLEEP, rand_level());
    pick = $urandom_range(99);
    if (pick < 65) send(FUNC_POSTED, rand_level());
    else if (pick < 85) send(FUNC_CANCELED, rand_level());
    repeat ($urandom_range(6)) send(FUNC_SLEEP, rand_level());
  endtask

  task automatic config_visit();
    send(FUNC_ENTER_CFG, rand_level());
    repeat ($urandom_range(3)) send(FUNC_SLEEP, rand_level());
    if ($urandom_range(99) < 30) send(FUNC_MEASURE, near_level());
    if ($urandom_range(99) < 80) send(FUNC_LEAVE_CFG, rand_level());
  endtask

  task automatic run_events(input int n);
    int goal;
    int pick;
    goal = sent + n;
    while (sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 10) send(FUNC_W'($urandom_range(7)), rand_level());
      else if (pick < 20) config_visit();
      else measure_cycle();
      if (sent >= next_pause) begin
        settle();
        next_pause += 150;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MIN_DIFF;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_MEASURE;
    send_idle_pct = 0;
    stall_pct     = 0;
    sent          = 0;
    next_pause    = 150;
    deadband_now  = int'(MIN_DIFF_RST);
    base_level    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: first measure posts on an empty countdown.
    send(FUNC_SLEEP, rand_level());
    send(FUNC_MEASURE, LB'(0));
    send(FUNC_SLEEP, rand_level());
    send(FUNC_MEASURE, LB'(10));
    send(FUNC_POSTED, rand_level());
    send(FUNC_MEASURE, LB'(59));
    send(FUNC_MEASURE, LB'(60));
    send(FUNC_CANCELED, rand_level());
    send(FUNC_RSVD_6, rand_level());
    send(FUNC_RSVD_7, rand_level());
    send(FUNC_ENTER_CFG, rand_level());
    send(FUNC_SLEEP, rand_level());
    send(FUNC_MEASURE, LB'(-131072));
    send(FUNC_SLEEP, rand_level());
    send(FUNC_LEAVE_CFG, rand_level());
    send(FUNC_POSTED, rand_level());
    send(FUNC_MEASURE, LB'(131071));
    send(FUNC_POSTED, rand_level());
    send(FUNC_SLEEP, rand_level());
    send(FUNC_MEASURE, LB'(LEVEL_INVALID));

    // Zero deadband, widest reload, zero and over-range sleep lengths.
    settle();
    program_regs(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    send(FUNC_POSTED, rand_level());
    send(FUNC_MEASURE, LB'(LEVEL_INVALID));
    send(FUNC_SLEEP, rand_level());
    send(FUNC_CANCELED, rand_level());
    send(FUNC_SLEEP, rand_level());

    settle();
    program_regs(16'hFFFF, 16'd1, 16'd4294, 16'd4294);
    send(FUNC_POSTED, rand_level());
    send(FUNC_SLEEP, rand_level());
    send(FUNC_SLEEP, rand_level());
    send(FUNC_MEASURE, LB'(0));

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          program_regs(CFG_DATA_W'($urandom_range(200)), CFG_DATA_W'($urandom_range(10)),
                       CFG_DATA_W'($urandom_range(4294, 1)),
                       CFG_DATA_W'($urandom_range(4294, 1)));
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          program_regs(16'd0, 16'd0, 16'd1, 16'd1);
          send_idle_pct = 84;
          stall_pct     = 0;
        end
        2: begin
          program_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                       CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
          send_idle_pct = 0;
          stall_pct     = 84;
        end
        default: begin
          program_regs(CFG_DATA_W'($urandom_range(500)), CFG_DATA_W'($urandom_range(20)),
                       16'd4294, 16'd4294);
          send_idle_pct = 14;
          stall_pct     = 14;
        end
      endcase
      run_events(500);
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("report_on_change_sleep_controller: match");
    end else begin
      $display("report_on_change_sleep_controller: mismatch");
    end
    $finish;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("report_on_change_sleep_controller: mismatch");
    $finish;
  end

endmodule
